FILE: sv/hsv_pkg.sv
// Shared types, constants and sector routing for the HSV to RGB converter.
package hsv_pkg;

  localparam int unsigned CW      = 16;
  localparam int unsigned LATENCY = 4;
  localparam int unsigned SECTORS = 6;

  typedef logic [CW-1:0] color_t;
  typedef logic [CW:0]   frac1_t;
  typedef logic [2:0]    sector_t;

  localparam frac1_t  ONE = frac1_t'(1) << CW;

  localparam sector_t SEC_RY = 3'd0;
  localparam sector_t SEC_YG = 3'd1;
  localparam sector_t SEC_GC = 3'd2;
  localparam sector_t SEC_CB = 3'd3;
  localparam sector_t SEC_BM = 3'd4;
  localparam sector_t SEC_MR = 3'd5;

  typedef struct packed {
    color_t hue;
    color_t saturation;
    color_t brightness;
  } hsv_req_t;

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
  } rgb_res_t;

  function automatic rgb_res_t route(sector_t sec, color_t v, color_t p, color_t q, color_t t);
    rgb_res_t r;
    unique case (sec)
      SEC_RY:  r = '{red: v, green: t, blue: p};
      SEC_YG:  r = '{red: q, green: v, blue: p};
      SEC_GC:  r = '{red: p, green: v, blue: t};
      SEC_CB:  r = '{red: p, green: q, blue: v};
      SEC_BM:  r = '{red: t, green: p, blue: v};
      default: r = '{red: v, green: p, blue: q};
    endcase
    return r;
  endfunction

endpackage

FILE: sv/hsv_qmul.sv
// Registered Q0.W multiply, a * b >> W truncated, b may equal one.
module hsv_qmul (
  input  logic           clk_i,
  input  hsv_pkg::color_t a_i,
  input  hsv_pkg::frac1_t b_i,
  output hsv_pkg::color_t p_o
);
  import hsv_pkg::*;

  logic [2*CW-1:0] prod;
  color_t          p_q;

  assign prod = (2*CW)'(a_i) * (2*CW)'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= prod[2*CW-1:CW];
  end

  assign p_o = p_q;

endmodule

FILE: sv/hsv_to_rgb_converter.sv
// Top level of the pipelined HSV to RGB converter.
// Takes one request per clock whenever start_i is high; busy_o stays low since
// nothing downstream can stall. Each result appears on res_o with done_o high for
// exactly one cycle, after its request has passed the register stages: hue times six, then the
// three products s*f, s*(1-f) and v*(1-s), then v*(1-sf) and v*(1-s(1-f)), then
// sector routing. Zero saturation yields grey through the same path.
module hsv_to_rgb_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  hsv_pkg::hsv_req_t req_i,
  output logic              done_o,
  output hsv_pkg::rgb_res_t res_o
);
  import hsv_pkg::*;

  logic [LATENCY-1:0] vld_q, vld_d;

  // stage 1: sector and fraction
  logic [CW+2:0] h6;
  sector_t sec1_q, sec2_q, sec3_q;
  color_t  frac1_q, sat1_q, val1_q, val2_q, val3_q;
  // stage 2/3 products
  color_t  sf2, s1f2, p2, q3, t3, p3_q;
  rgb_res_t res_q;

  assign h6 = (CW+3)'(req_i.hue) * (CW+3)'(SECTORS);

  assign vld_d = {vld_q[LATENCY-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sec1_q  <= h6[CW+2:CW];
    frac1_q <= h6[CW-1:0];
    sat1_q  <= req_i.saturation;
    val1_q  <= req_i.brightness;
    sec2_q  <= sec1_q;
    val2_q  <= val1_q;
    sec3_q  <= sec2_q;
    val3_q  <= val2_q;
    p3_q    <= p2;
    res_q   <= route(sec3_q, val3_q, p3_q, q3, t3);
  end

  hsv_qmul u_sf (
    .clk_i (clk_i),
    .a_i   (sat1_q),
    .b_i   ({1'b0, frac1_q}),
    .p_o   (sf2)
  );

  hsv_qmul u_s1f (
    .clk_i (clk_i),
    .a_i   (sat1_q),
    .b_i   (ONE - {1'b0, frac1_q}),
    .p_o   (s1f2)
  );

  hsv_qmul u_p (
    .clk_i (clk_i),
    .a_i   (val1_q),
    .b_i   (ONE - {1'b0, sat1_q}),
    .p_o   (p2)
  );

  hsv_qmul u_q (
    .clk_i (clk_i),
    .a_i   (val2_q),
    .b_i   (ONE - {1'b0, sf2}),
    .p_o   (q3)
  );

  hsv_qmul u_t (
    .clk_i (clk_i),
    .a_i   (val2_q),
    .b_i   (ONE - {1'b0, s1f2}),
    .p_o   (t3)
  );

  assign busy_o = 1'b0;
  assign done_o = vld_q[LATENCY-1];
  assign res_o  = res_q;

endmodule

FILE: sv/hsv_checker.sv
// Port-level checker for the HSV to RGB converter, bound to the top level.
module hsv_port_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input hsv_pkg::hsv_req_t req_i,
  input logic              done_o,
  input hsv_pkg::rgb_res_t res_o
);
  import hsv_pkg::*;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy asserted");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##4 done_o)
    else $error("request produced no result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 4))
    else $error("result without request");

  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.saturation == '0 |-> ##4
      res_o.red == $past(req_i.brightness, 4) && res_o.green == res_o.red &&
      res_o.blue == res_o.red)
    else $error("zero saturation not grey");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##4
      res_o.red <= $past(req_i.brightness, 4) &&
      res_o.green <= $past(req_i.brightness, 4) &&
      res_o.blue <= $past(req_i.brightness, 4))
    else $error("component exceeds value");

endmodule

bind hsv_to_rgb_converter hsv_port_checker u_hsv_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .res_o   (res_o)
);
